/* rtl/fprx_pkg.sv */
// fprx_pkg: types and constants shared by the framed packet receiver
// no dependencies
package fprx_pkg;

    localparam int BYTE_W    = 8;
    localparam int PKT_LEN_W = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'd1;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h03;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN,
        PH_DATA,
        PH_CHK,
        PH_ETX,
        PH_PLAY
    } phase_t;

endpackage

/* rtl/framed_packet_receiver_xor_unit.sv */
// Framed packet receiver: hunts for a start marker, takes a length byte (1 to BUF_DEPTH-1),
// stores that many payload bytes in a RAM with registered read data while folding an XOR checksum,
// then checks the checksum byte and the end marker. A good frame is played out from the RAM
// as one output item per payload byte, the last flagged; a bad length, checksum or end marker
// gives one error item. Input bytes are taken at one per cycle while the read stage is empty
// and, for the length, checksum and end marker bytes, the output register is free. During
// playout no input is taken; one RAM read per cycle, unless a read byte waits on the output.
// depends on fprx_pkg and fprx_buf
module framed_packet_receiver_xor_unit #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fprx_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fprx_pkg::BYTE_W-1:0]          cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [fprx_pkg::BYTE_W-1:0]          rx_byte,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [fprx_pkg::BYTE_W-1:0]          payload_byte,
    output logic [fprx_pkg::PKT_LEN_W-1:0]       packet_length,
    output logic                                 last_of_packet,
    output logic                                 is_error
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam logic [fprx_pkg::BYTE_W:0] DEPTH_LIM = (fprx_pkg::BYTE_W+1)'(BUF_DEPTH);

    logic [fprx_pkg::BYTE_W-1:0] start_marker_reg;
    logic [fprx_pkg::BYTE_W-1:0] end_marker_reg;

    fprx_pkg::phase_t phase_reg, phase_next;
    logic [AW-1:0] len_reg, len_next;
    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [fprx_pkg::BYTE_W-1:0] xor_reg, xor_next;

    logic stage_valid_reg, stage_valid_next;
    logic stage_last_reg, stage_last_next;

    logic                          out_valid_reg, out_valid_next;
    logic [fprx_pkg::BYTE_W-1:0]   out_byte_reg, out_byte_next;
    logic [fprx_pkg::PKT_LEN_W-1:0] out_len_reg, out_len_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_err_reg, out_err_next;

    logic in_fire;
    logic len_ok;
    logic out_free;
    logic stage_move;
    logic rd_en;
    logic err_fire;
    logic wr_en;
    logic rd_last;
    logic [AW-1:0] wr_idx_inc;
    logic [AW-1:0] rd_idx_inc;
    logic [fprx_pkg::BYTE_W-1:0] rd_data;

    assign out_free   = !out_valid_reg || out_ready;
    assign in_fire    = in_valid && in_ready;
    assign len_ok     = (rx_byte != '0) && ({1'b0, rx_byte} < DEPTH_LIM);
    assign wr_idx_inc = wr_idx_reg + AW'(1);
    assign rd_idx_inc = rd_idx_reg + AW'(1);
    assign rd_last    = (rd_idx_inc == len_reg);
    assign stage_move = stage_valid_reg && out_free;

    // handshake and datapath controls
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        err_fire = 1'b0;
        wr_en    = 1'b0;
        unique case (phase_reg)
            fprx_pkg::PH_HUNT,
            fprx_pkg::PH_DATA:
            begin
                in_ready = !stage_valid_reg;
                wr_en    = in_valid && in_ready && (phase_reg == fprx_pkg::PH_DATA);
            end
            fprx_pkg::PH_LEN:
            begin
                in_ready = !stage_valid_reg && out_free;
                err_fire = in_valid && in_ready && !len_ok;
            end
            fprx_pkg::PH_CHK:
            begin
                in_ready = !stage_valid_reg && out_free;
                err_fire = in_valid && in_ready && (rx_byte != xor_reg);
            end
            fprx_pkg::PH_ETX:
            begin
                in_ready = !stage_valid_reg && out_free;
                err_fire = in_valid && in_ready && (rx_byte != end_marker_reg);
            end
            fprx_pkg::PH_PLAY:
            begin
                rd_en = !stage_valid_reg || stage_move;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        len_next    = len_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        xor_next    = xor_reg;
        unique case (phase_reg)
            fprx_pkg::PH_HUNT:
            begin
                if (in_fire && (rx_byte == start_marker_reg))
                begin
                    phase_next = fprx_pkg::PH_LEN;
                    xor_next   = '0;
                end
            end
            fprx_pkg::PH_LEN:
            begin
                if (in_fire)
                begin
                    if (len_ok)
                    begin
                        phase_next  = fprx_pkg::PH_DATA;
                        len_next    = rx_byte[AW-1:0];
                        wr_idx_next = '0;
                    end
                    else
                    begin
                        phase_next = fprx_pkg::PH_HUNT;
                    end
                end
            end
            fprx_pkg::PH_DATA:
            begin
                if (in_fire)
                begin
                    wr_idx_next = wr_idx_inc;
                    xor_next    = xor_reg ^ rx_byte;
                    if (wr_idx_inc == len_reg)
                    begin
                        phase_next = fprx_pkg::PH_CHK;
                    end
                end
            end
            fprx_pkg::PH_CHK:
            begin
                if (in_fire)
                begin
                    phase_next = err_fire ? fprx_pkg::PH_HUNT : fprx_pkg::PH_ETX;
                end
            end
            fprx_pkg::PH_ETX:
            begin
                if (in_fire)
                begin
                    phase_next  = err_fire ? fprx_pkg::PH_HUNT : fprx_pkg::PH_PLAY;
                    rd_idx_next = '0;
                end
            end
            fprx_pkg::PH_PLAY:
            begin
                if (rd_en)
                begin
                    rd_idx_next = rd_idx_inc;
                    if (rd_last)
                    begin
                        phase_next = fprx_pkg::PH_HUNT;
                    end
                end
            end
            default:
            begin
                phase_next = fprx_pkg::PH_HUNT;
            end
        endcase
    end

    // read stage and output register
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_last_next  = stage_last_reg;
        if (rd_en)
        begin
            stage_valid_next = 1'b1;
            stage_last_next  = rd_last;
        end
        else if (stage_move)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        if (stage_move)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = rd_data;
            out_len_next   = fprx_pkg::PKT_LEN_W'(len_reg);
            out_last_next  = stage_last_reg;
            out_err_next   = 1'b0;
        end
        else if (err_fire)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = '0;
            out_len_next   = '0;
            out_last_next  = 1'b1;
            out_err_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= fprx_pkg::START_MARKER_RST;
            end_marker_reg   <= fprx_pkg::END_MARKER_RST;
            phase_reg        <= fprx_pkg::PH_HUNT;
            len_reg          <= '0;
            wr_idx_reg       <= '0;
            rd_idx_reg       <= '0;
            xor_reg          <= '0;
            stage_valid_reg  <= 1'b0;
            stage_last_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fprx_pkg::CFG_START_MARKER: start_marker_reg <= cfg_data;
                    fprx_pkg::CFG_END_MARKER:   end_marker_reg   <= cfg_data;
                    default:                    start_marker_reg <= start_marker_reg;
                endcase
            end
            phase_reg       <= phase_next;
            len_reg         <= len_next;
            wr_idx_reg      <= wr_idx_next;
            rd_idx_reg      <= rd_idx_next;
            xor_reg         <= xor_next;
            stage_valid_reg <= stage_valid_next;
            stage_last_reg  <= stage_last_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    fprx_buf #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    assign out_valid      = out_valid_reg;
    assign payload_byte   = out_byte_reg;
    assign packet_length  = out_len_reg;
    assign last_of_packet = out_last_reg;
    assign is_error       = out_err_reg;

endmodule

/* rtl/fprx_buf.sv */
// fprx_buf: payload store, one write port and one read port, registered read data
// depends on fprx_pkg
module fprx_buf #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [fprx_pkg::BYTE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    output logic [fprx_pkg::BYTE_W-1:0] rd_data
);

    logic [fprx_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [fprx_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sim/tb.sv */
// tb: self-checking bench for framed_packet_receiver_xor_unit, random frames with
// random handshake gaps, expected output items worked out per accepted byte
// depends on fprx_pkg and the receiver rtl
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BUF_DEPTH = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [fprx_pkg::BYTE_W-1:0]    data;
        logic [fprx_pkg::PKT_LEN_W-1:0] len;
        logic                           last;
        logic                           err;
    } rx_result_t;

    typedef enum {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_END,
        FR_BAD_LEN
    } frame_kind_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [fprx_pkg::CFG_IDX_W-1:0]  cfg_index = fprx_pkg::CFG_START_MARKER;
    logic [fprx_pkg::BYTE_W-1:0]     cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [fprx_pkg::BYTE_W-1:0]     rx_byte = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [fprx_pkg::BYTE_W-1:0]     payload_byte;
    logic [fprx_pkg::PKT_LEN_W-1:0]  packet_length;
    logic                            last_of_packet;
    logic                            is_error;

    logic [fprx_pkg::BYTE_W-1:0]     rx_stream_q[$];
    rx_result_t                      frame_out_q[$];

    // receiver model state
    logic [fprx_pkg::BYTE_W-1:0]     start_mk = fprx_pkg::START_MARKER_RST;
    logic [fprx_pkg::BYTE_W-1:0]     end_mk = fprx_pkg::END_MARKER_RST;
    fprx_pkg::phase_t                ph = fprx_pkg::PH_HUNT;
    logic [fprx_pkg::BYTE_W-1:0]     pkt_store [BUF_DEPTH];
    logic [fprx_pkg::PKT_LEN_W-1:0]  exp_len = '0;
    logic [fprx_pkg::PKT_LEN_W-1:0]  wr_idx = '0;
    logic [fprx_pkg::BYTE_W-1:0]     run_xor = '0;

    logic                            steady = 1'b0;
    logic                            rand_on = 1'b0;
    logic                            hold_done = 1'b0;
    int                              hold_left = 0;
    int                              mismatches = 0;
    int                              cycles = 0;

    framed_packet_receiver_xor_unit #(
        .BUF_DEPTH(BUF_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .payload_byte(payload_byte),
        .packet_length(packet_length),
        .last_of_packet(last_of_packet),
        .is_error(is_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic deframe_byte(input logic [fprx_pkg::BYTE_W-1:0] b);
        logic bad;
        logic close;
        int   i;
        bad = 1'b0;
        close = 1'b0;
        case (ph)
            fprx_pkg::PH_LEN:
            begin
                if (b >= 1 && b < BUF_DEPTH)
                begin
                    exp_len = b[fprx_pkg::PKT_LEN_W-1:0];
                    wr_idx = '0;
                    ph = fprx_pkg::PH_DATA;
                end
                else
                begin
                    bad = 1'b1;
                end
            end
            fprx_pkg::PH_DATA:
            begin
                pkt_store[wr_idx] = b;
                run_xor = run_xor ^ b;
                wr_idx = wr_idx + 1'b1;
                if (wr_idx == exp_len)
                    ph = fprx_pkg::PH_CHK;
            end
            fprx_pkg::PH_CHK:
            begin
                if (b == run_xor)
                    ph = fprx_pkg::PH_ETX;
                else
                    bad = 1'b1;
            end
            fprx_pkg::PH_ETX:
            begin
                if (b != end_mk)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    for (i = 0; i < exp_len; i++)
                        frame_out_q.push_back('{data: pkt_store[i], len: exp_len,
                                                last: (i == exp_len - 1), err: 1'b0});
                    close = 1'b1;
                end
            end
            default:
            begin
                if (b == start_mk)
                    ph = fprx_pkg::PH_LEN;
            end
        endcase
        if (bad)
            frame_out_q.push_back('{data: '0, len: '0, last: 1'b1, err: 1'b1});
        if (bad || close)
        begin
            ph = fprx_pkg::PH_HUNT;
            exp_len = '0;
            wr_idx = '0;
            run_xor = '0;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= '0;
        end
        else
        begin : drive
            logic take;
            take = in_valid && in_ready;
            if (take)
                deframe_byte(rx_byte);
            if (!in_valid || take)
            begin
                if (rx_stream_q.size() != 0 && (steady || $urandom_range(0, 99) >= 37))
                begin
                    in_valid <= 1'b1;
                    rx_byte <= rx_stream_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver side, with one long hold-off once random traffic starts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (rand_on && !hold_done && out_valid)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= steady || ($urandom_range(0, 99) >= 37);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin : check
            rx_result_t got;
            rx_result_t want;
            got = '{data: payload_byte, len: packet_length, last: last_of_packet,
                    err: is_error};
            if (frame_out_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: byte %h len %0d last %b err %b",
                             got.data, got.len, got.last, got.err);
            end
            else
            begin
                want = frame_out_q.pop_front();
                if (got.data !== want.data || got.len !== want.len ||
                    got.last !== want.last || got.err !== want.err)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: byte %h/%h len %0d/%0d last %b/%b err %b/%b",
                                 want.data, got.data, want.len, got.len,
                                 want.last, got.last, want.err, got.err);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [fprx_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fprx_pkg::BYTE_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == fprx_pkg::CFG_START_MARKER)
            start_mk = val;
        else
            end_mk = val;
    endtask

    // for a bad length frame, len is the length byte itself
    task automatic queue_frame(input int len, input frame_kind_t kind);
        logic [fprx_pkg::BYTE_W-1:0] sum;
        logic [fprx_pkg::BYTE_W-1:0] d;
        int                          i;
        sum = '0;
        rx_stream_q.push_back(start_mk);
        rx_stream_q.push_back(len[fprx_pkg::BYTE_W-1:0]);
        if (kind != FR_BAD_LEN)
        begin
            for (i = 0; i < len; i++)
            begin
                d = fprx_pkg::BYTE_W'($urandom_range(0, 255));
                sum = sum ^ d;
                rx_stream_q.push_back(d);
            end
            if (kind == FR_BAD_SUM)
                sum = sum ^ fprx_pkg::BYTE_W'($urandom_range(1, 255));
            rx_stream_q.push_back(sum);
            if (kind != FR_BAD_SUM)
                rx_stream_q.push_back(kind == FR_BAD_END ?
                                      end_mk ^ fprx_pkg::BYTE_W'($urandom_range(1, 255)) :
                                      end_mk);
        end
    endtask

    task automatic random_traffic(input int n_bytes);
        int start_sz;
        int r;
        int len;
        int i;
        start_sz = rx_stream_q.size();
        while (rx_stream_q.size() - start_sz < n_bytes)
        begin
            r = $urandom_range(0, 99);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 6);
            if (r < 70)
                queue_frame(len, FR_GOOD);
            else if (r < 78)
                queue_frame(len, FR_BAD_SUM);
            else if (r < 86)
                queue_frame(len, FR_BAD_END);
            else if (r < 93)
                queue_frame($urandom_range(0, 1) ? 0 : $urandom_range(64, 255), FR_BAD_LEN);
            else
                for (i = $urandom_range(1, 3); i > 0; i--)
                    rx_stream_q.push_back(fprx_pkg::BYTE_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic drain();
        while (rx_stream_q.size() != 0 || in_valid)
            @(posedge clk);
        while (frame_out_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset markers, hunting noise and each kind of framing error
        rx_stream_q.push_back(8'h00);
        rx_stream_q.push_back(8'hFF);
        rx_stream_q.push_back(fprx_pkg::END_MARKER_RST);
        queue_frame(1, FR_GOOD);
        queue_frame(0, FR_BAD_LEN);
        queue_frame(64, FR_BAD_LEN);
        queue_frame(255, FR_BAD_LEN);
        queue_frame(2, FR_BAD_SUM);
        queue_frame(1, FR_BAD_END);
        queue_frame(2, FR_GOOD);
        drain();

        // length byte equal to the start marker is not a new start
        write_reg(fprx_pkg::CFG_START_MARKER, 8'h00);
        write_reg(fprx_pkg::CFG_END_MARKER, 8'hFF);
        queue_frame(0, FR_BAD_LEN);
        queue_frame(1, FR_GOOD);
        rand_on = 1'b1;
        queue_frame(63, FR_GOOD);
        random_traffic(25);
        drain();

        write_reg(fprx_pkg::CFG_START_MARKER, 8'hFF);
        write_reg(fprx_pkg::CFG_END_MARKER, 8'h00);
        queue_frame(255, FR_BAD_LEN);
        queue_frame(1, FR_GOOD);
        steady = 1'b1;
        random_traffic(25);
        drain();
        steady = 1'b0;

        write_reg(fprx_pkg::CFG_START_MARKER, fprx_pkg::BYTE_W'($urandom_range(0, 255)));
        write_reg(fprx_pkg::CFG_END_MARKER, start_mk);
        random_traffic(25);
        drain();

        write_reg(fprx_pkg::CFG_START_MARKER, fprx_pkg::BYTE_W'($urandom_range(0, 255)));
        write_reg(fprx_pkg::CFG_END_MARKER, fprx_pkg::BYTE_W'($urandom_range(0, 255)));
        random_traffic(25);
        drain();

        if (mismatches == 0 && frame_out_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

/* sim.f */
rtl/fprx_pkg.sv
rtl/fprx_buf.sv
rtl/framed_packet_receiver_xor_unit.sv
sim/tb.sv
